FILE: src/twrc_pkg.sv
// Package: request types and time widths for the route time-window checker.
package twrc_pkg;

    localparam int TIME_W  = 32;
    localparam int TS_W    = TIME_W + 1;
    localparam int TOTAL_W = 40;

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [TOTAL_W-1:0] total_t;

    typedef struct packed {
        logic  first_stop;
        time_t start_time;
        time_t travel_time;
        time_t service_time;
        time_t window_open;
        time_t window_close;
        time_t return_time;
        logic  last_stop;
    } stop_req_t;

    typedef struct packed {
        logic   feasible;
        total_t travel_total;
    } result_req_t;

    // staged stop with travel + service already summed
    typedef struct packed {
        logic            first_stop;
        logic            last_stop;
        time_t           start_time;
        time_t           travel_time;
        logic [TS_W-1:0] ts_sum;
        time_t           window_open;
        time_t           window_close;
        time_t           return_time;
    } stage_t;

endpackage

FILE: src/time_window_route_check.sv
// Top level: route time-window feasibility checker with valid/stall channels.
//
// Stops of one route arrive on in_req in route order, depot request first
// (first_stop set, carrying start_time). Each later stop request carries its
// travel, service and window; the request with last_stop set also carries the
// return leg and produces one result request on out_req: feasible and the
// pure travel time (zero when infeasible). Other stops produce no result.
// Throughput is one stop request per cycle while in_stall is low. An accepted
// request is held in the input stage and evaluated there; a last stop's result
// is registered on out_req when it leaves the stage. The route clock update is one
// pass of adds and compares between the input stage and the output register.
// Reset clears the route state and both stages and sets end_time to the
// largest value. cfg_write loads end_time; write it only while idle.
// When out_stall holds a result, stops that yield no result keep flowing;
// a last stop waits in the input stage and in_stall rises behind it.
module time_window_route_check
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  twrc_pkg::time_t         cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  twrc_pkg::stop_req_t     in_req,
    output logic                    out_valid,
    input  logic                    out_stall,
    output twrc_pkg::result_req_t   out_req
);

    twrc_pkg::time_t       end_time_reg, end_time_next;
    logic                  stage_valid_reg, stage_valid_next;
    twrc_pkg::stage_t      stage_reg, stage_next;
    logic                  out_valid_reg, out_valid_next;
    twrc_pkg::result_req_t out_req_reg, out_req_next;
    twrc_pkg::result_req_t result;
    logic                  out_free;
    logic                  advance;
    logic                  accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = stage_valid_reg && (!stage_reg.last_stop || out_free);
    assign in_stall = stage_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        end_time_next = cfg_write ? cfg_data : end_time_reg;

        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (accept)
        begin
            stage_valid_next        = 1'b1;
            stage_next.first_stop   = in_req.first_stop;
            stage_next.last_stop    = in_req.last_stop;
            stage_next.start_time   = in_req.start_time;
            stage_next.travel_time  = in_req.travel_time;
            stage_next.ts_sum       = twrc_pkg::TS_W'(in_req.travel_time)
                                    + twrc_pkg::TS_W'(in_req.service_time);
            stage_next.window_open  = in_req.window_open;
            stage_next.window_close = in_req.window_close;
            stage_next.return_time  = in_req.return_time;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_req_next   = out_req_reg;
        if (advance && stage_reg.last_stop)
        begin
            out_valid_next = 1'b1;
            out_req_next   = result;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    twrc_stop_eval u_eval
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .stop     (stage_reg),
        .end_time (end_time_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_time_reg    <= '1;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            end_time_reg    <= end_time_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg   <= stage_next;
        out_req_reg <= out_req_next;
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

endmodule

FILE: src/twrc_stop_eval.sv
// Route state and single-pass evaluation of one staged stop.
module twrc_stop_eval
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  twrc_pkg::stage_t      stop,
    input  twrc_pkg::time_t       end_time,
    output twrc_pkg::result_req_t result
);

    localparam int ARR_W = twrc_pkg::TIME_W + 2;
    localparam int FIN_W = twrc_pkg::TIME_W + 3;

    twrc_pkg::time_t clock_reg, clock_next;
    twrc_pkg::time_t tsum_reg, tsum_next;
    logic            failed_reg, failed_next;

    logic [ARR_W-1:0]              arr;
    logic [ARR_W-1:0]              waited;
    logic [ARR_W-1:0]              cur_clock;
    logic [twrc_pkg::TS_W-1:0]     tsum_cur;
    logic [FIN_W-1:0]              fin;
    logic [ARR_W-1:0]              total;
    logic                          stop_fail;
    logic                          cur_fail;
    logic                          ok;

    always_comb
    begin
        arr = ARR_W'(clock_reg) + ARR_W'(stop.ts_sum);
        if (arr < ARR_W'(stop.window_open))
        begin
            waited = ARR_W'(stop.window_open);
        end
        else
        begin
            waited = arr;
        end
        stop_fail = !stop.first_stop &&
                    ((waited > ARR_W'(stop.window_close)) || (waited > ARR_W'(end_time)));
        if (stop.first_stop)
        begin
            cur_clock = ARR_W'(stop.start_time);
            tsum_cur  = '0;
            cur_fail  = 1'b0;
        end
        else
        begin
            cur_clock = waited;
            tsum_cur  = twrc_pkg::TS_W'(tsum_reg) + twrc_pkg::TS_W'(stop.travel_time);
            cur_fail  = failed_reg | stop_fail;
        end
        fin   = FIN_W'(cur_clock) + FIN_W'(stop.return_time);
        total = ARR_W'(tsum_cur) + ARR_W'(stop.return_time);
        ok    = !cur_fail && !(fin > FIN_W'(end_time));
        result.feasible     = ok;
        result.travel_total = ok ? twrc_pkg::TOTAL_W'(total) : '0;
    end

    // values kept past a stop only matter while the route has not failed,
    // and then they fit in the time width
    always_comb
    begin
        clock_next  = clock_reg;
        tsum_next   = tsum_reg;
        failed_next = failed_reg;
        if (step)
        begin
            if (stop.last_stop)
            begin
                clock_next  = '0;
                tsum_next   = '0;
                failed_next = 1'b0;
            end
            else
            begin
                clock_next  = cur_clock[twrc_pkg::TIME_W-1:0];
                tsum_next   = tsum_cur[twrc_pkg::TIME_W-1:0];
                failed_next = cur_fail;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg  <= '0;
            tsum_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            clock_reg  <= clock_next;
            tsum_reg   <= tsum_next;
            failed_reg <= failed_next;
        end
    end

endmodule
